FILE: design/ccpdt_pkg.sv
// ----------------------------------------------------------------------------
// ccpdt_pkg: shared constants for the packed date/time calendar clock
// Field widths, limits, reset values and command codes used by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccpdt_pkg;

  // Command codes carried on in_tuser.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Stream data widths: three fields packed, padded to whole bytes.
  localparam int WORD_W   = 16;
  localparam int SEC_W    = 6;
  localparam int FIELDS_W = 2 * WORD_W + SEC_W;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

  // Limits of the calendar fields.
  localparam logic [6:0] SEC_LAST  = 7'd59;
  localparam logic [6:0] MIN_LAST  = 7'd59;
  localparam logic [5:0] HOUR_LAST = 6'd23;
  localparam logic [4:0] MON_LAST  = 5'd12;

  // Month lengths.
  localparam logic [4:0] DAYS_LONG   = 5'd31;
  localparam logic [4:0] DAYS_SHORT  = 5'd30;
  localparam logic [4:0] DAYS_FEB_LY = 5'd29;
  localparam logic [4:0] DAYS_FEB    = 5'd28;
  localparam logic [3:0] MON_FEB     = 4'd2;

  // Reset state: midnight, 1 January 1980.
  localparam logic [WORD_W-1:0] TIME_RESET = 16'd0;
  localparam logic [WORD_W-1:0] DATE_RESET = 16'd33;
  localparam logic [SEC_W-1:0]  SEC_RESET  = 6'd0;

endpackage

FILE: design/calendar_clock_packed_date_time.sv
// An accepted item is held in the input stage, then in the clock state registers.
// Throughput: one item per cycle while out_tready is high; the calendar update is
// a single pass of short carry logic between input stage and clock state registers.
// Reset (rst_n low, synchronous): clock returns to 00:00:00 on 1 January 1980,
// both stages are emptied and no result is offered.
// ----------------------------------------------------------------------------
// calendar_clock_packed_date_time: calendar clock with packed date/time words
// Advances the clock by one second per tick item or loads new values, and
// returns the packed time word, packed date word and seconds count after
// every item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_clock_packed_date_time (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Bits 15..0 load_time_word, 31..16 load_date_word, 37..32 load_seconds,
  // 39..38 zero.
  input  logic [ccpdt_pkg::TDATA_W-1:0]  in_tdata,
  // Bit 0 command (tick or load).
  input  logic                           in_tuser,
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Bits 15..0 time_word, 31..16 date_word, 37..32 seconds, 39..38 zero.
  output logic [ccpdt_pkg::TDATA_W-1:0]  out_tdata
);

  localparam int WW = ccpdt_pkg::WORD_W;
  localparam int SW = ccpdt_pkg::SEC_W;

  // --------------------------------------------------------------------------
  // Input stage. It holds one item so that the input side keeps moving while
  // a finished result waits on the output. It drains into the clock state
  // whenever the result register is empty or being emptied this cycle.
  // --------------------------------------------------------------------------
  logic          s1_valid_r;
  logic          s1_cmd_r;
  logic [WW-1:0] s1_time_r;
  logic [WW-1:0] s1_date_r;
  logic [SW-1:0] s1_sec_r;

  logic out_valid_r;
  logic s1_advance;
  logic in_fire;

  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_fire    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_tuser;
      s1_time_r <= in_tdata[WW-1:0];
      s1_date_r <= in_tdata[2*WW-1:WW];
      s1_sec_r  <= in_tdata[2*WW+SW-1:2*WW];
    end
  end

  // --------------------------------------------------------------------------
  // Clock state. These registers are also the result register: after each
  // item they hold exactly the values the result reports.
  // --------------------------------------------------------------------------
  logic [WW-1:0] time_r, time_nxt;
  logic [WW-1:0] date_r, date_nxt;
  logic [SW-1:0] sec_r,  sec_nxt;

  // Tick arithmetic. Each field is compared against its limit even when no
  // carry arrives, so out-of-range loaded values fold back on the next tick.
  logic [6:0] sec_inc;
  logic       sec_carry;
  logic [6:0] min_inc;
  logic       min_carry;
  logic [5:0] min_new;
  logic [5:0] hr_inc;
  logic       hr_carry;
  logic [4:0] hr_new;
  logic [5:0] day_inc;
  logic [4:0] day_last;
  logic       day_carry;
  logic [4:0] day_new;
  logic [4:0] mon_inc;
  logic       mon_carry;
  logic [3:0] mon_new;
  logic [6:0] yr_new;
  logic [3:0] mon_cur;
  logic [6:0] yr_cur;

  assign mon_cur = date_r[8:5];
  assign yr_cur  = date_r[15:9];

  always_comb begin
    sec_inc   = {1'b0, sec_r} + 7'd1;
    sec_carry = sec_inc > ccpdt_pkg::SEC_LAST;

    min_inc   = {1'b0, time_r[10:5]} + {6'd0, sec_carry};
    min_carry = min_inc > ccpdt_pkg::MIN_LAST;
    min_new   = min_carry ? 6'd0 : min_inc[5:0];

    hr_inc    = {1'b0, time_r[15:11]} + {5'd0, min_carry};
    hr_carry  = hr_inc > ccpdt_pkg::HOUR_LAST;
    hr_new    = hr_carry ? 5'd0 : hr_inc[4:0];

    // Month length: February follows the year-multiple-of-four rule; other
    // months alternate, odd months long below August, even months long from
    // August on. Out-of-range months follow the same pattern.
    if (mon_cur == ccpdt_pkg::MON_FEB) begin
      day_last = (yr_cur[1:0] == 2'd0) ? ccpdt_pkg::DAYS_FEB_LY : ccpdt_pkg::DAYS_FEB;
    end else if (mon_cur[3] ^ mon_cur[0]) begin
      day_last = ccpdt_pkg::DAYS_LONG;
    end else begin
      day_last = ccpdt_pkg::DAYS_SHORT;
    end

    day_inc   = {1'b0, date_r[4:0]} + {5'd0, hr_carry};
    day_carry = day_inc > {1'b0, day_last};
    day_new   = day_carry ? 5'd1 : day_inc[4:0];

    mon_inc   = {1'b0, mon_cur} + {4'd0, day_carry};
    mon_carry = mon_inc > ccpdt_pkg::MON_LAST;
    mon_new   = mon_carry ? 4'd1 : mon_inc[3:0];

    // The year offset simply wraps in seven bits, 2107 back to 1980.
    yr_new    = yr_cur + {6'd0, mon_carry};

    if (s1_cmd_r == ccpdt_pkg::CMD_LOAD) begin
      time_nxt = s1_time_r;
      date_nxt = s1_date_r;
      sec_nxt  = s1_sec_r;
    end else begin
      sec_nxt  = sec_carry ? 6'd0 : sec_inc[5:0];
      time_nxt = {hr_new, min_new, sec_nxt[5:1]};
      date_nxt = {yr_new, mon_new, day_new};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= ccpdt_pkg::TIME_RESET;
      date_r      <= ccpdt_pkg::DATE_RESET;
      sec_r       <= ccpdt_pkg::SEC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_advance) begin
        time_r <= time_nxt;
        date_r <= date_nxt;
        sec_r  <= sec_nxt;
      end
      if (s1_advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ccpdt_pkg::TDATA_W - ccpdt_pkg::FIELDS_W){1'b0}},
                       sec_r, date_r, time_r};

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------
  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance |=> out_valid_r)
    else $error("item left the input stage without producing a result");

  a_tick_seconds_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && s1_cmd_r == ccpdt_pkg::CMD_TICK) |=>
      ({1'b0, sec_r} <= ccpdt_pkg::SEC_LAST))
    else $error("tick left seconds count out of range");

  a_tick_halfsec_field: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && s1_cmd_r == ccpdt_pkg::CMD_TICK) |=> (time_r[4:0] == sec_r[5:1]))
    else $error("tick time word does not match seconds count");

  a_tick_hour_minute_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && s1_cmd_r == ccpdt_pkg::CMD_TICK) |=>
      ({1'b0, time_r[15:11]} <= ccpdt_pkg::HOUR_LAST &&
       {1'b0, time_r[10:5]} <= ccpdt_pkg::MIN_LAST))
    else $error("tick left hours or minutes out of range");

  a_load_stores_as_given: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && s1_cmd_r == ccpdt_pkg::CMD_LOAD) |=>
      (time_r == $past(s1_time_r) && date_r == $past(s1_date_r) &&
       sec_r == $past(s1_sec_r)))
    else $error("load item not stored unchanged");

endmodule
